[rtl/core/life_generation_engine_defines.svh]
// Assertion macros shared by the life generation engine RTL.
`ifndef LIFE_GENERATION_ENGINE_DEFINES_SVH
`define LIFE_GENERATION_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define LGE_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: assertion failed");
`define LGE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: assertion failed");
`else
`define LGE_ASSERT(label, ante, cons)
`define LGE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/core/lge_pkg.sv]
// Package with types, constants and helpers of the life generation engine.
package lge_pkg;

   localparam int ROWS = 64;
   localparam int COLS = 64;
   localparam int ROW_W = 6;
   localparam int CELL_W = 64;
   localparam int ROW_AW = $clog2(ROWS);
   localparam int CNT_W = $clog2(ROWS + 2);
   localparam int NBR_W = 4;

   localparam logic [CNT_W-1:0] CNT_ROWS = CNT_W'(ROWS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROWS + 1);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
   localparam logic [ROW_AW-1:0] ROW_TOP = ROW_AW'(ROWS - 1);
   localparam logic [ROW_W:0] ROWS_LIMIT = (ROW_W + 1)'(ROWS);

   localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;
   localparam logic [NBR_W-1:0] KEEP_COUNT = 4'd2;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } lge_state_type;

   typedef struct packed {
      logic              req_type;
      logic [ROW_W-1:0]  row_index;
      logic [CELL_W-1:0] row_cells;
   } lge_req_word_type;

   typedef struct packed {
      logic [ROW_W-1:0]  out_row;
      logic [CELL_W-1:0] out_cells;
      logic              last_row;
   } lge_rsp_word_type;

   typedef struct packed {
      logic              go;
      logic [ROW_AW-1:0] row;
      logic              last;
   } lge_row_ctl_type;

   function automatic logic [ROW_W-1:0] row_to_out(input logic [ROW_AW-1:0] a);
      return ROW_W'(a);
   endfunction

   function automatic logic [CELL_W-1:0] cells_to_out(input logic [COLS-1:0] c);
      return CELL_W'(c);
   endfunction

endpackage

[rtl/core/life_generation_engine.sv]
// Top level of the toroidal Game of Life engine with a row-wide bank of cell lanes.
// A load word is written to the board RAM and gives no result.
// A step word stalls the input until its last row is registered, so a new step word is
// only accepted once the step is done; the board RAM delivers one row per cycle while the
// output does not stall, and the rows' results are registered in row order at the output.
// Reset is synchronous and clears the board at once through per-row valid bits.
`include "life_generation_engine_defines.svh"

module life_generation_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lge_pkg::lge_req_word_type req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lge_pkg::lge_rsp_word_type rsp_word
);

   lge_pkg::lge_state_type state_ff;
   lge_pkg::lge_state_type state_in;

   logic [lge_pkg::CNT_W-1:0]  rd_cnt_ff;
   logic [lge_pkg::CNT_W-1:0]  rd_cnt_in;
   logic [lge_pkg::CNT_W-1:0]  sh_cnt_ff;
   logic [lge_pkg::CNT_W-1:0]  sh_cnt_in;
   logic                       pend_ff;
   logic                       pend_in;
   logic [lge_pkg::ROWS-1:0]   vld_ff;
   logic [lge_pkg::ROWS-1:0]   vld_in;
   logic                       rd_vld_ff;
   logic                       rd_vld_in;
   logic [lge_pkg::COLS-1:0]   first_ff;
   logic [lge_pkg::COLS-1:0]   win_above_ff;
   logic [lge_pkg::COLS-1:0]   win_here_ff;

   logic                       step_go;
   logic                       load_go;
   logic                       load_ok;
   logic                       running;
   logic                       from_ram;
   logic                       produces;
   logic                       out_free;
   logic                       shift;
   logic                       sh_from_ram;
   logic                       row_go;
   logic                       rd_issue;
   logic [lge_pkg::CNT_W-1:0]  rd_cnt_m1;
   logic [lge_pkg::CNT_W-1:0]  row_num;
   logic [lge_pkg::ROW_AW-1:0] rd_addr;
   logic [lge_pkg::ROW_AW-1:0] wr_addr;
   logic [lge_pkg::COLS-1:0]   wr_data;
   logic                       wr_en;
   logic [lge_pkg::COLS-1:0]   rd_data;
   logic [lge_pkg::COLS-1:0]   incoming;
   logic [lge_pkg::COLS-1:0]   fresh_row;
   lge_pkg::lge_row_ctl_type   row_ctl;

   always_comb begin
      unique case (state_ff)
         lge_pkg::ST_IDLE: begin
            state_in = step_go ? lge_pkg::ST_RUN : lge_pkg::ST_IDLE;
         end
         lge_pkg::ST_RUN: begin
            state_in = (shift && (sh_cnt_ff == lge_pkg::CNT_LAST)) ?
                       lge_pkg::ST_IDLE : lge_pkg::ST_RUN;
         end
         default: begin
            state_in = lge_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      unique case (state_ff)
         lge_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            running   = 1'b0;
         end
         lge_pkg::ST_RUN: begin
            req_stall = 1'b1;
            running   = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
            running   = 1'b0;
         end
      endcase
   end

   always_comb begin
      step_go  = req_valid && !req_stall && (req_word.req_type == lge_pkg::REQ_STEP);
      load_go  = req_valid && !req_stall && (req_word.req_type == lge_pkg::REQ_LOAD);
      load_ok  = load_go && ({1'b0, req_word.row_index} < lge_pkg::ROWS_LIMIT);

      from_ram = sh_cnt_ff <= lge_pkg::CNT_ROWS;
      produces = sh_cnt_ff >= lge_pkg::CNT_TWO;
      out_free = !rsp_valid || !rsp_stall;
      shift    = running && (from_ram ? pend_ff : (sh_cnt_ff == lge_pkg::CNT_LAST)) &&
                 (!produces || out_free);
      sh_from_ram = shift && from_ram;
      row_go   = shift && produces;

      rd_issue  = running && (rd_cnt_ff <= lge_pkg::CNT_ROWS) && (!pend_ff || sh_from_ram);
      rd_cnt_m1 = rd_cnt_ff - lge_pkg::CNT_ONE;
      rd_addr   = (rd_cnt_ff == '0) ? lge_pkg::ROW_TOP : rd_cnt_m1[lge_pkg::ROW_AW-1:0];

      incoming = from_ram ? (rd_vld_ff ? rd_data : '0) : first_ff;

      row_num      = sh_cnt_ff - lge_pkg::CNT_TWO;
      row_ctl.go   = row_go;
      row_ctl.row  = row_num[lge_pkg::ROW_AW-1:0];
      row_ctl.last = sh_cnt_ff == lge_pkg::CNT_LAST;

      wr_en   = load_ok || row_go;
      wr_addr = row_go ? row_num[lge_pkg::ROW_AW-1:0] :
                req_word.row_index[lge_pkg::ROW_AW-1:0];
      wr_data = row_go ? fresh_row : req_word.row_cells[lge_pkg::COLS-1:0];

      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end

      rd_vld_in = rd_issue ? vld_ff[rd_addr] : rd_vld_ff;
      pend_in   = rd_issue ? 1'b1 : (sh_from_ram ? 1'b0 : pend_ff);
      rd_cnt_in = step_go ? '0 : (rd_issue ? rd_cnt_ff + lge_pkg::CNT_ONE : rd_cnt_ff);
      sh_cnt_in = step_go ? '0 : (shift ? sh_cnt_ff + lge_pkg::CNT_ONE : sh_cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lge_pkg::ST_IDLE;
         rd_cnt_ff <= '0;
         sh_cnt_ff <= '0;
         pend_ff   <= 1'b0;
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_cnt_ff <= rd_cnt_in;
         sh_cnt_ff <= sh_cnt_in;
         pend_ff   <= pend_in;
         vld_ff    <= vld_in;
         rd_vld_ff <= rd_vld_in;
      end
      if (shift) begin
         win_above_ff <= win_here_ff;
         win_here_ff  <= incoming;
      end
      if (shift && (sh_cnt_ff == lge_pkg::CNT_ONE)) begin
         first_ff <= incoming;
      end
   end

   lge_ram #(
      .WIDTH (lge_pkg::COLS),
      .DEPTH (lge_pkg::ROWS)
   ) u_board (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lge_row_engine u_rows (
      .clock     (clock),
      .reset     (reset),
      .ctl       (row_ctl),
      .above     (win_above_ff),
      .here      (win_here_ff),
      .below     (incoming),
      .rsp_stall (rsp_stall),
      .fresh_row (fresh_row),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   `LGE_ASSERT(a_no_result_overwrite, row_go, !rsp_valid || !rsp_stall)
   `LGE_ASSERT(a_idle_no_pending_read, state_ff == lge_pkg::ST_IDLE, !pend_ff)
   `LGE_ASSERT_NEXT(a_last_row_ends_step, row_go && row_ctl.last, state_ff == lge_pkg::ST_IDLE)
   `LGE_ASSERT(a_read_slot_free, rd_issue, !pend_ff || sh_from_ram)

endmodule

[rtl/core/lge_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module lge_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/lge_lane.sv]
// One cell lane: counts the eight neighbors of a cell and applies the rule.
module lge_lane (
   input  logic [7:0] nbr,
   input  logic       alive,
   output logic       next_alive
);

   logic [lge_pkg::NBR_W-1:0] count;

   always_comb begin
      count = '0;
      for (int k = 0; k < 8; k++) begin
         count = count + {3'b000, nbr[k]};
      end
      next_alive = (count == lge_pkg::BIRTH_COUNT) ||
                   (alive && (count == lge_pkg::KEEP_COUNT));
   end

endmodule

[rtl/core/lge_row_engine.sv]
// Row of cell lanes on a torus and the output register that merges their results.
module lge_row_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  lge_pkg::lge_row_ctl_type  ctl,
   input  logic [lge_pkg::COLS-1:0]  above,
   input  logic [lge_pkg::COLS-1:0]  here,
   input  logic [lge_pkg::COLS-1:0]  below,
   input  logic                      rsp_stall,
   output logic [lge_pkg::COLS-1:0]  fresh_row,
   output logic                      rsp_valid,
   output lge_pkg::lge_rsp_word_type rsp_word
);

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   lge_pkg::lge_rsp_word_type rsp_word_ff;
   lge_pkg::lge_rsp_word_type rsp_word_in;

   for (genvar c = 0; c < lge_pkg::COLS; c++) begin : g_lane
      localparam int CW = (c + lge_pkg::COLS - 1) % lge_pkg::COLS;
      localparam int CE = (c + 1) % lge_pkg::COLS;

      lge_lane u_lane (
         .nbr        ({above[CW], above[c], above[CE], here[CW], here[CE],
                       below[CW], below[c], below[CE]}),
         .alive      (here[c]),
         .next_alive (fresh_row[c])
      );
   end

   always_comb begin
      rsp_word_in.out_row   = lge_pkg::row_to_out(ctl.row);
      rsp_word_in.out_cells = lge_pkg::cells_to_out(fresh_row);
      rsp_word_in.last_row  = ctl.last;
      rsp_valid_in          = ctl.go || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (ctl.go) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
